// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the firmware upload receiver datapath.
// Needs nothing else; fwup_dp includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/fwup_pkg.sv =====
// Shared constants and types of the firmware upload receiver.
// Used by fwup_ctrl, fwup_dp and the top level; depends on nothing.
package fwup_pkg;

   localparam int DEF_PAGE_BYTES = 1024;
   localparam int REPORT_BYTES   = 64;
   localparam int REP_AW         = 6;
   localparam int REQ_DW         = 16;
   localparam int RSP_DW         = 80;

   localparam logic [31:0] DEF_FLASH_BASE = 32'h0000_4000;
   localparam logic [7:0]  HDR_MARK  = 8'hCA;
   localparam logic [31:0] START_SEQ = 32'hA5A5_A5A5;
   localparam logic [31:0] DONE_SEQ  = 32'h5A5A_5A5A;
   localparam logic [7:0]  OP_DATA   = 8'h12;
   localparam logic [7:0]  OP_OTHER  = 8'h33;
   localparam logic [7:0]  OP_LAUNCH = 8'hA5;
   localparam logic [7:0]  CHUNK_MAX = 8'd32;
   localparam logic [7:0]  LEN_MAX   = 8'd59;
   localparam logic [7:0]  START_LEN = 8'd12;
   localparam logic [7:0]  SHORT_LEN = 8'd4;

   typedef enum logic [9:0] {
      ST_RECV = 10'b00_0000_0001,
      ST_PRD  = 10'b00_0000_0010,
      ST_SCAN = 10'b00_0000_0100,
      ST_EVAL = 10'b00_0000_1000,
      ST_COPY = 10'b00_0001_0000,
      ST_UPD  = 10'b00_0010_0000,
      ST_PAGE = 10'b00_0100_0000,
      ST_ADDR = 10'b00_1000_0000,
      ST_SUM  = 10'b01_0000_0000,
      ST_SEND = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic rx_wr;
      logic pg_rd;
      logic pg_ld;
      logic scan_go;
      logic eval;
      logic copy_go;
      logic upd;
      logic page;
      logic addr;
      logic sum;
      logic send_go;
      logic cnt_clr;
   } cmd_type;

   typedef struct packed {
      logic mode;
      logic pos_last;
      logic scan_done;
      logic frame_ok;
      logic data_seq;
      logic copy_need;
      logic copy_done;
      logic cnt_last;
      logic out_free;
   } sts_type;

endpackage

// ===== rtl/core/firmware_upload_frame_receiver_top.sv =====
// Top level of the firmware upload receiver: ports, packing, and the
// controller and datapath. Depends on fwup_pkg, fwup_ctrl and fwup_dp.
//
//   channel   direction  contents
//   req_*     in         tuser = mode; tdata = rx_byte, word_index
//   rsp_*     out        tuser = kind; tlast = tx_last; tdata = reply or page word
//   csr_*     in         flash_base write
//
// A report byte is taken while the output is free; the 64th byte starts a check
// that reads the report memory once through its single port, then, for a good
// frame, a payload copy of one byte a cycle on a matching sequence, bookkeeping
// and 64 reply beats, one a cycle while the sink is ready. A page word read is
// registered, then loaded in ST_PRD. Reset is synchronous and active high; it
// clears the page valid bits at once, so no clearing pass is needed. A stalled
// sink holds the output register and the sequencer; no beat is lost.
module firmware_upload_frame_receiver_top #(
   parameter int PAGE_BYTES = fwup_pkg::DEF_PAGE_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [31:0]                    csr_wr_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fwup_pkg::REQ_DW-1:0]    req_tdata,  // rx_byte[7:0], word_index[15:8]
   input  logic                           req_tuser,  // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fwup_pkg::RSP_DW-1:0]    rsp_tdata,  // tx_byte[7:0], commit_page[8],
                                                      // commit_address[40:9],
                                                      // launch_request[41],
                                                      // page_word[73:42], zeros
   output logic                           rsp_tuser,  // kind
   output logic                           rsp_tlast   // tx_last
);
   import fwup_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [7:0]  o_byte;
   logic        o_commit, o_launch;
   logic [31:0] o_caddr, o_word;

   fwup_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fwup_dp #(.PAGE_BYTES(PAGE_BYTES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mode        (req_tuser),
      .rx_byte     (req_tdata[7:0]),
      .word_index  (req_tdata[15:8]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .o_kind      (rsp_tuser),
      .o_byte      (o_byte),
      .o_last      (rsp_tlast),
      .o_commit    (o_commit),
      .o_caddr     (o_caddr),
      .o_launch    (o_launch),
      .o_word      (o_word)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {6'd0, o_word, o_launch, o_caddr, o_commit, o_byte};

endmodule

// ===== rtl/core/fwup_ctrl.sv =====
// Sequencer of the firmware upload receiver: one-hot state machine.
// Depends on fwup_pkg; drives commands into fwup_dp.
module fwup_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  fwup_pkg::sts_type sts,
   output fwup_pkg::cmd_type cmd
);
   import fwup_pkg::*;

   state_type state_ff, state_in;
   logic      acc;

   assign req_tready = (state_ff == ST_RECV) && sts.out_free;
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RECV: begin
            if (acc && sts.mode) state_in = ST_PRD;
            else if (acc && sts.pos_last) state_in = ST_SCAN;
         end
         ST_PRD:  state_in = ST_RECV;
         ST_SCAN: if (sts.scan_done) state_in = ST_EVAL;
         ST_EVAL: begin
            if (!sts.frame_ok) state_in = ST_RECV;
            else if (sts.copy_need) state_in = ST_COPY;
            else if (sts.data_seq) state_in = ST_UPD;
            else state_in = ST_SUM;
         end
         ST_COPY: if (sts.copy_done) state_in = ST_UPD;
         ST_UPD:  state_in = ST_PAGE;
         ST_PAGE: state_in = ST_ADDR;
         ST_ADDR: state_in = ST_SUM;
         ST_SUM:  state_in = ST_SEND;
         ST_SEND: if (sts.out_free && sts.cnt_last) state_in = ST_RECV;
         default: state_in = ST_RECV;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.rx_wr   = acc && !sts.mode;
      cmd.pg_rd   = acc && sts.mode;
      cmd.pg_ld   = (state_ff == ST_PRD);
      cmd.scan_go = (state_ff == ST_SCAN);
      cmd.eval    = (state_ff == ST_EVAL);
      cmd.copy_go = (state_ff == ST_COPY);
      cmd.upd     = (state_ff == ST_UPD);
      cmd.page    = (state_ff == ST_PAGE);
      cmd.addr    = (state_ff == ST_ADDR);
      cmd.sum     = (state_ff == ST_SUM);
      cmd.send_go = (state_ff == ST_SEND) && sts.out_free;
      cmd.cnt_clr = (state_ff == ST_RECV) || (state_ff == ST_EVAL) || (state_ff == ST_SUM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/fwup_dp.sv =====
// Datapath of the firmware upload receiver: report and page memories,
// frame checks, offset bookkeeping and the output register. Uses fwup_pkg.
`include "assert_macros.svh"
module fwup_dp #(
   parameter int PAGE_BYTES = fwup_pkg::DEF_PAGE_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   input  logic              mode,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        word_index,
   input  fwup_pkg::cmd_type cmd,
   output fwup_pkg::sts_type sts,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic              o_kind,
   output logic [7:0]        o_byte,
   output logic              o_last,
   output logic              o_commit,
   output logic [31:0]       o_caddr,
   output logic              o_launch,
   output logic [31:0]       o_word
);
   import fwup_pkg::*;

   localparam int PB_W = $clog2(PAGE_BYTES);
   localparam int PW   = PAGE_BYTES / 4;
   localparam int PW_W = $clog2(PW);

   // report memory and its read pipeline
   logic [7:0]        rep_mem [REPORT_BYTES];
   logic [7:0]        rep_rd_ff;
   logic [REP_AW-1:0] pos_ff, rd_idx_ff, cp_i_ff, rd_addr;
   logic              sc_vld_ff, cp_vld_ff, sc_iss, cp_iss;
   logic [6:0]        cnt_ff;

   // frame fields
   logic [7:0]  hdr_ff, len_ff, op_ff, sum_ff, chk_ff;
   logic [63:0] ech_ff;
   logic [7:0]  idx_off;
   logic [31:0] seq;

   // offset bookkeeping and reply
   logic [31:0] fb_ff, exp_ff, size_ff, pgoff_ff, caddr_ff;
   logic [5:0]  pay_ff;
   logic        match_ff, ge_ff, commit_ff, launch_ff, r12_ff;
   logic [7:0]  rlen_ff, rop_ff, rchk_ff, rb, sum8;
   logic [63:0] rdat_ff;
   logic [5:0]  k;
   logic [2:0]  ksel;

   // page memory
   logic [7:0]   pg_mem [4][PW];
   logic [PW-1:0] pv_ff;
   logic [7:0]   pg_rd_ff [4];
   logic         pv_rd_ff;
   logic [PW_W-1:0] ridx;
   logic         rin;
   logic [PB_W:0] pba;
   logic [PW_W-1:0] wword;
   logic [1:0]   wlane;

   logic ov_ff;

   assign seq   = ech_ff[31:0];
   assign sc_iss = cmd.scan_go && !cnt_ff[6];
   assign cp_iss = cmd.copy_go && (cnt_ff < 7'(pay_ff));
   assign rd_addr = sc_iss ? cnt_ff[REP_AW-1:0] : REP_AW'(6'd8 + cnt_ff[5:0]);
   assign idx_off = 8'(rd_idx_ff) - 8'd4;
   assign ridx  = PW_W'(32'(word_index));
   assign rin   = 32'(word_index) < 32'(PW);
   assign pba   = {1'b0, exp_ff[PB_W-1:0]} + (PB_W+1)'(cp_i_ff);
   assign wword = pba[PB_W-1:2];
   assign wlane = pba[1:0];

   // report memory
   always_ff @(posedge clock) begin
      if (cmd.rx_wr) rep_mem[pos_ff] <= rx_byte;
      rep_rd_ff <= rep_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sc_vld_ff <= 1'b0;
         cp_vld_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (cmd.rx_wr) pos_ff <= pos_ff + 1'b1;
         sc_vld_ff <= sc_iss;
         cp_vld_ff <= cp_iss;
         if (cmd.cnt_clr) cnt_ff <= '0;
         else if (sc_iss || cp_iss || cmd.send_go) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      cp_i_ff   <= cnt_ff[5:0];
   end

   // scan of a complete report
   always_ff @(posedge clock) begin
      if (sc_vld_ff) begin
         if (rd_idx_ff == 6'd0) hdr_ff <= rep_rd_ff;
         if (rd_idx_ff == 6'd1) len_ff <= rep_rd_ff;
         if (rd_idx_ff == 6'd3) op_ff <= rep_rd_ff;
         for (int j = 0; j < 8; j++) begin
            if (rd_idx_ff == REP_AW'(4 + j)) ech_ff[8*j +: 8] <= rep_rd_ff;
         end
         if (rd_idx_ff == 6'd0) sum_ff <= '0;
         else if (rd_idx_ff >= 6'd4 && idx_off < len_ff) sum_ff <= sum_ff + rep_rd_ff;
         if (9'(rd_idx_ff) == 9'(len_ff) + 9'd4) chk_ff <= rep_rd_ff;
      end
   end

   // reply checksum: unused data bytes are zero, so all eight are summed
   always_comb begin
      sum8 = r12_ff ? CHUNK_MAX : 8'd0;
      for (int j = 0; j < 8; j++) sum8 = sum8 + rdat_ff[8*j +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff   <= DEF_FLASH_BASE;
         exp_ff  <= '0;
         size_ff <= '0;
      end else begin
         if (csr_wr_en) fb_ff <= csr_wr_data;
         if (cmd.eval && sts.frame_ok && op_ff == OP_DATA && seq == START_SEQ) begin
            exp_ff  <= '0;
            size_ff <= ech_ff[63:32];
         end
         if (cmd.upd && match_ff) exp_ff <= exp_ff + 32'(pay_ff);
         if (cmd.addr && ge_ff) exp_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         commit_ff <= 1'b0;
         match_ff  <= (seq == exp_ff);
         pay_ff    <= (len_ff >= SHORT_LEN) ? 6'(len_ff - SHORT_LEN) : 6'd0;
         if (op_ff == OP_DATA) begin
            launch_ff <= 1'b0;
            rop_ff    <= OP_DATA;
            if (seq == START_SEQ) begin
               rlen_ff <= START_LEN;
               rdat_ff <= ech_ff;
               r12_ff  <= 1'b1;
            end else begin
               rlen_ff <= SHORT_LEN;
               rdat_ff <= '0;
               r12_ff  <= 1'b0;
            end
         end else if (op_ff == OP_LAUNCH) begin
            launch_ff <= 1'b1;
            rlen_ff   <= 8'd0;
            rop_ff    <= 8'd0;
            rdat_ff   <= '0;
            r12_ff    <= 1'b0;
         end else begin
            launch_ff <= 1'b0;
            rlen_ff   <= SHORT_LEN;
            rop_ff    <= OP_OTHER;
            rdat_ff   <= {32'd0, START_SEQ};
            r12_ff    <= 1'b0;
         end
      end
      if (cmd.page) begin
         commit_ff <= match_ff && (pay_ff != 6'd0) &&
                      ((exp_ff[PB_W-1:0] == '0) || (exp_ff >= size_ff));
         ge_ff     <= exp_ff >= size_ff;
         pgoff_ff  <= (exp_ff[PB_W-1:0] == '0) ? exp_ff - 32'(PAGE_BYTES)
                                                 : {exp_ff[31:PB_W], PB_W'(0)};
      end
      if (cmd.addr) begin
         caddr_ff <= fb_ff + pgoff_ff;
         rdat_ff  <= {32'd0, ge_ff ? DONE_SEQ : exp_ff};
      end
      if (cmd.sum) rchk_ff <= sum8;
   end

   // reply byte for the current send position
   assign k    = cnt_ff[5:0];
   assign ksel = 3'(k - 6'd4);
   always_comb begin
      rb = 8'd0;
      if (k == 6'd0) rb = HDR_MARK;
      else if (k == 6'd1) rb = rlen_ff;
      else if (k == 6'd3) rb = rop_ff;
      else if (9'(k) == 9'(rlen_ff) + 9'd4) rb = rchk_ff;
      else if (k == 6'd12 && r12_ff) rb = CHUNK_MAX;
      else if (k >= 6'd4 && k < 6'd12) rb = rdat_ff[{ksel, 3'b000} +: 8];
   end

   // page memory: a word that is not valid reads as all ones, so a byte
   // written into it fills the other lanes with 0xFF
   always_ff @(posedge clock) begin
      for (int l = 0; l < 4; l++) begin
         if (cp_vld_ff && !pba[PB_W] && (wlane == 2'(l) || !pv_ff[wword])) begin
            pg_mem[l][wword] <= (wlane == 2'(l)) ? rep_rd_ff : 8'hFF;
         end
         if (cmd.pg_rd) pg_rd_ff[l] <= pg_mem[l][ridx];
      end
      if (cmd.pg_rd) pv_rd_ff <= rin && pv_ff[ridx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else begin
         if (cp_vld_ff && !pba[PB_W]) pv_ff[wword] <= 1'b1;
         if (cmd.pg_rd && rin) pv_ff[ridx] <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.pg_ld || cmd.send_go) begin
         ov_ff <= 1'b1;
      end else if (rsp_tready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pg_ld) begin
         o_kind   <= 1'b1;
         o_byte   <= '0;
         o_last   <= 1'b0;
         o_commit <= 1'b0;
         o_caddr  <= '0;
         o_launch <= 1'b0;
         o_word   <= pv_rd_ff ? {pg_rd_ff[3], pg_rd_ff[2], pg_rd_ff[1], pg_rd_ff[0]}
                              : 32'hFFFF_FFFF;
      end else if (cmd.send_go) begin
         o_kind   <= 1'b0;
         o_byte   <= rb;
         o_last   <= (k == 6'd63);
         o_commit <= (k == 6'd0) && commit_ff;
         o_caddr  <= ((k == 6'd0) && commit_ff) ? caddr_ff : 32'd0;
         o_launch <= (k == 6'd0) && launch_ff;
         o_word   <= '0;
      end
   end

   assign rsp_tvalid = ov_ff;

   always_comb begin
      sts           = '0;
      sts.mode      = mode;
      sts.pos_last  = (pos_ff == 6'd63);
      sts.scan_done = sc_vld_ff && (rd_idx_ff == 6'd63);
      sts.frame_ok  = (hdr_ff == HDR_MARK) && (len_ff <= LEN_MAX) && (sum_ff == chk_ff);
      sts.data_seq  = (op_ff == OP_DATA) && (seq != START_SEQ);
      sts.copy_need = sts.data_seq && (seq == exp_ff) && (len_ff > SHORT_LEN);
      sts.copy_done = (cnt_ff >= 7'(pay_ff)) && !cp_vld_ff;
      sts.cnt_last  = (k == 6'd63);
      sts.out_free  = !ov_ff || rsp_tready;
   end

   `ASSERT_IMPL(a_scan_copy_apart, clock, reset, cp_vld_ff, !sc_vld_ff)
   `ASSERT_NEXT(a_scan_ends, clock, reset, sc_vld_ff && rd_idx_ff == 6'd63, !sc_vld_ff)
   `ASSERT_IMPL(a_commit_on_header, clock, reset, ov_ff && o_commit, !o_kind && o_byte == HDR_MARK)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for firmware_upload_frame_receiver_top.
// Depends on fwup_pkg and the top level; drives whole reports and page reads.
module tb;
   import fwup_pkg::*;

   localparam int PG_BYTES   = 1024;
   localparam int HOLD_OFF   = 300;
   localparam int STALL_MAX  = 20000;

   typedef struct {
      bit         mode;
      logic [7:0] rx;
      logic [7:0] idx;
   } req_item_t;

   typedef struct packed {
      bit          kind;
      logic [7:0]  tx;
      bit          last;
      bit          commit;
      logic [31:0] addr;
      bit          launch;
      logic [31:0] word;
   } reply_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;   // rx_byte, word_index
   logic        req_tuser = 1'b0;       // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;        // tx_byte, commit_page, commit_address,
                                        // launch_request, page_word
   logic        rsp_tuser;              // kind
   logic        rsp_tlast;              // tx_last

   firmware_upload_frame_receiver_top u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   // Beats waiting to be sent, and reply beats the block still owes us.
   req_item_t   pending_beats[$];
   reply_beat_t owed_beats[$];

   int  src_idle_pct = 0;
   int  snk_stall_pct = 0;
   int  read_pct = 5;
   int  issued = 0;
   int  accepted = 0;
   int  quiet_cycles = 0;
   bit  failed = 1'b0;

   // Shadow copy of the block's state, advanced on each accepted beat.
   logic [7:0]  sh_report[64];
   int          sh_pos = 0;
   logic [7:0]  sh_page[PG_BYTES];
   logic [31:0] sh_offset = '0;
   logic [31:0] sh_size = '0;
   logic [31:0] sh_base = DEF_FLASH_BASE;

   // Offset and image size as the stimulus side believes them to be, so that
   // most data reports carry the right sequence.
   logic [31:0] gen_offset = '0;
   logic [31:0] gen_size = '0;

   initial begin
      for (int i = 0; i < PG_BYTES; i++) sh_page[i] = 8'hFF;
      for (int i = 0; i < 64; i++) sh_report[i] = '0;
   end

   function automatic logic [7:0] byte_sum(logic [7:0] b[64], int first, int n);
      logic [7:0] s;
      s = '0;
      for (int i = 0; i < n; i++) s = s + b[first + i];
      return s;
   endfunction

   // Works out the reply to a complete report and updates the shadow state.
   function automatic void answer_report();
      logic [7:0]  tx[64];
      logic [31:0] seq;
      logic [31:0] addr;
      int          len, pay, at;
      bit          commit, launch;
      reply_beat_t beat;
      len = sh_report[1];
      commit = 1'b0;
      launch = 1'b0;
      addr = '0;
      if (sh_report[0] != HDR_MARK || len > LEN_MAX) return;
      if (byte_sum(sh_report, 4, len) != sh_report[len + 4]) return;
      for (int i = 0; i < 64; i++) tx[i] = '0;
      if (sh_report[3] == OP_DATA) begin
         seq = {sh_report[7], sh_report[6], sh_report[5], sh_report[4]};
         if (seq == START_SEQ) begin
            sh_offset = '0;
            sh_size = {sh_report[11], sh_report[10], sh_report[9], sh_report[8]};
            tx[1] = START_LEN;
            tx[3] = OP_DATA;
            for (int i = 4; i < 12; i++) tx[i] = sh_report[i];
            tx[12] = CHUNK_MAX;
         end else begin
            if (seq == sh_offset) begin
               pay = (len >= 4) ? len - 4 : 0;
               at = seq % PG_BYTES;
               // Bytes that would run past the page end are dropped.
               for (int i = 0; i < pay; i++)
                  if (at + i < PG_BYTES) sh_page[at + i] = sh_report[8 + i];
               sh_offset = sh_offset + pay;
               if (pay != 0) begin
                  if (sh_offset % PG_BYTES == 0) begin
                     commit = 1'b1;
                     addr = sh_base + sh_offset - PG_BYTES;
                  end else if (sh_offset >= sh_size) begin
                     commit = 1'b1;
                     addr = sh_base + (sh_offset / PG_BYTES) * PG_BYTES;
                  end
               end
            end
            seq = sh_offset;
            if (sh_offset >= sh_size) begin
               sh_offset = '0;
               seq = DONE_SEQ;
            end
            tx[1] = SHORT_LEN;
            tx[3] = OP_DATA;
            {tx[7], tx[6], tx[5], tx[4]} = seq;
         end
      end else if (sh_report[3] == OP_LAUNCH) begin
         launch = 1'b1;
      end else begin
         tx[1] = SHORT_LEN;
         tx[3] = OP_OTHER;
         {tx[7], tx[6], tx[5], tx[4]} = START_SEQ;
      end
      tx[0] = HDR_MARK;
      tx[tx[1] + 4] = byte_sum(tx, 4, tx[1]);
      for (int k = 0; k < 64; k++) begin
         beat.kind = 1'b0;
         beat.tx = tx[k];
         beat.last = (k == 63);
         beat.commit = (k == 0) && commit;
         beat.addr = (k == 0 && commit) ? addr : '0;
         beat.launch = (k == 0) && launch;
         beat.word = '0;
         owed_beats.push_back(beat);
      end
   endfunction

   function automatic void accept_beat(bit mode, logic [7:0] rx, logic [7:0] idx);
      reply_beat_t beat;
      int          w;
      if (mode) begin
         beat = '{1'b1, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'hFFFF_FFFF};
         w = idx;
         if (w < PG_BYTES / 4) begin
            beat.word = {sh_page[w*4+3], sh_page[w*4+2], sh_page[w*4+1], sh_page[w*4]};
            for (int i = 0; i < 4; i++) sh_page[w*4+i] = 8'hFF;
         end
         owed_beats.push_back(beat);
      end else begin
         sh_report[sh_pos] = rx;
         if (sh_pos == 63) begin
            sh_pos = 0;
            answer_report();
         end else begin
            sh_pos = sh_pos + 1;
         end
      end
   endfunction

   // Queues the 64 bytes of one report, with page reads mixed in at random.
   // bytes[4..] supply the body; the checksum lands at len+4 if len <= LEN_MAX.
   task automatic queue_report(logic [7:0] hdr, logic [7:0] len, logic [7:0] op,
                               logic [7:0] body[$], bit bad_sum);
      logic [7:0]  r[64];
      logic [31:0] seq;
      int          pay;
      req_item_t   it;
      for (int i = 0; i < 64; i++) r[i] = $urandom_range(255);
      r[0] = hdr;
      r[1] = len;
      r[3] = op;
      for (int i = 0; i < body.size() && i < 60; i++) r[4 + i] = body[i];
      if (len <= LEN_MAX) begin
         r[len + 4] = byte_sum(r, 4, len);
         if (bad_sum) r[len + 4] = r[len + 4] ^ (8'h01 << $urandom_range(7));
      end
      // Follow what a good data report does to the offset.
      if (hdr == HDR_MARK && len <= LEN_MAX && !bad_sum && op == OP_DATA) begin
         seq = {r[7], r[6], r[5], r[4]};
         if (seq == START_SEQ) begin
            gen_offset = '0;
            gen_size = {r[11], r[10], r[9], r[8]};
         end else begin
            pay = (len >= 4) ? len - 4 : 0;
            if (seq == gen_offset) gen_offset = gen_offset + pay;
            if (gen_offset >= gen_size) gen_offset = '0;
         end
      end
      for (int i = 0; i < 64; i++) begin
         if ($urandom_range(99) < read_pct) begin
            it.mode = 1'b1;
            it.rx = $urandom_range(255);
            it.idx = $urandom_range(255);
            pending_beats.push_back(it);
         end
         it.mode = 1'b0;
         it.rx = r[i];
         it.idx = $urandom_range(255);
         pending_beats.push_back(it);
      end
   endtask

   task automatic queue_start(logic [31:0] size);
      logic [7:0] body[$];
      body = {};
      for (int i = 0; i < 4; i++) body.push_back(START_SEQ[8*i +: 8]);
      for (int i = 0; i < 4; i++) body.push_back(size[8*i +: 8]);
      queue_report(HDR_MARK, $urandom_range(8, LEN_MAX), OP_DATA, body, 1'b0);
   endtask

   // A data report; a nonzero skew puts a wrong sequence in it.
   task automatic queue_data(int pay, logic [31:0] skew);
      logic [7:0]  body[$];
      logic [31:0] seq;
      body = {};
      seq = gen_offset + skew;
      for (int i = 0; i < 4; i++) body.push_back(seq[8*i +: 8]);
      for (int i = 0; i < pay; i++) body.push_back($urandom_range(255));
      queue_report(HDR_MARK, pay + 4, OP_DATA, body, 1'b0);
   endtask

   task automatic queue_plain(logic [7:0] hdr, logic [7:0] len, logic [7:0] op, bit bad);
      logic [7:0] body[$];
      body = {};
      queue_report(hdr, len, op, body, bad);
   endtask

   // One report drawn from the random mix; most keep a live upload going.
   task automatic queue_random_report();
      int   pick;
      logic [7:0] op;
      pick = $urandom_range(99);
      if (pick < 8) queue_start(($urandom_range(9) == 0) ? $urandom_range(1024, 2200)
                                                         : $urandom_range(1, 600));
      else if (pick < 68) queue_data($urandom_range(0, 55), 0);
      else if (pick < 74) queue_data($urandom_range(0, 55), $urandom_range(1, 200));
      else if (pick < 78) queue_plain(HDR_MARK, $urandom_range(0, 3), OP_DATA, 1'b0);
      else if (pick < 82) queue_plain(HDR_MARK, $urandom_range(0, LEN_MAX), OP_LAUNCH, 1'b0);
      else if (pick < 86) begin
         do op = $urandom_range(255); while (op == OP_DATA || op == OP_LAUNCH);
         queue_plain(HDR_MARK, $urandom_range(0, LEN_MAX), op, 1'b0);
      end
      else if (pick < 90) begin
         do op = $urandom_range(255); while (op == HDR_MARK);
         queue_plain(op, $urandom_range(0, LEN_MAX), OP_DATA, 1'b0);
      end
      else if (pick < 95) queue_data($urandom_range(0, 55), 0) ;
      else if (pick < 98) queue_plain(HDR_MARK, $urandom_range(0, LEN_MAX), OP_DATA, 1'b1);
      else queue_plain(HDR_MARK, $urandom_range(LEN_MAX + 1, 255), OP_DATA, 1'b0);
   endtask

   // Waits until every beat is sent and every reply beat has come, then lets
   // the block settle in case the last report drew no reply.
   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_tvalid || owed_beats.size() != 0)
         @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   task automatic write_base(logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sh_base = value;
   endtask

   // Beats are launched at the falling edge; a beat stays up until taken.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
      if (!reset && !(req_tvalid && accepted != issued)) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_beats[0].mode;
            req_tdata <= {pending_beats[0].idx, pending_beats[0].rx};
            void'(pending_beats.pop_front());
            issued <= issued + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Accepted beats feed the shadow model; reply beats are checked in order.
   always @(posedge clock) begin
      reply_beat_t exp_beat;
      reply_beat_t got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accept_beat(req_tuser, req_tdata[7:0], req_tdata[15:8]);
            accepted <= accepted + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.tx = rsp_tdata[7:0];
            got.last = rsp_tlast;
            got.commit = rsp_tdata[8];
            got.addr = rsp_tdata[40:9];
            got.launch = rsp_tdata[41];
            got.word = rsp_tdata[73:42];
            if (owed_beats.size() == 0) begin
               $display("%0t unexpected beat: kind %0d data %h", $time, got.kind, rsp_tdata);
               failed = 1'b1;
            end else begin
               exp_beat = owed_beats.pop_front();
               if (got != exp_beat || rsp_tdata[79:74] != '0) begin
                  $display("%0t mismatch: expected kind %0d tx %h last %0d commit %0d addr %h launch %0d word %h",
                           $time, exp_beat.kind, exp_beat.tx, exp_beat.last, exp_beat.commit,
                           exp_beat.addr, exp_beat.launch, exp_beat.word);
                  $display("%0t          actual   kind %0d tx %h last %0d commit %0d addr %h launch %0d word %h",
                           $time, got.kind, got.tx, got.last, got.commit,
                           got.addr, got.launch, got.word);
                  failed = 1'b1;
               end
            end
         end
         // The watchdog restarts whenever either channel moves a beat.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_MAX) begin
            $display("FAIL firmware_upload_frame_receiver_top");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      logic [31:0] bases[4];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset base address: a short image whose one data
      // report runs past its end, then reads that drain the written words.
      read_pct = 0;
      queue_start(32'd20);
      queue_data(24, 0);
      wait_idle();
      for (int i = 0; i < 16; i++) pending_beats.push_back('{1'b1, 8'(i) ^ 8'h5A, 8'(i)});
      wait_idle();

      // Random part, one idling pattern per phase, each at its own base.
      bases[0] = 32'h0000_0000;
      bases[1] = $urandom;
      bases[2] = 32'hFFFF_FC00;
      bases[3] = DEF_FLASH_BASE;
      for (int ph = 0; ph < 4; ph++) begin
         write_base(bases[ph]);
         src_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 26 : 0;
         snk_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 26 : 0;
         read_pct = 5;
         queue_random_report();
         wait_idle();
      end

      if (!failed) begin
         $display("PASS firmware_upload_frame_receiver_top");
      end else begin
         $display("FAIL firmware_upload_frame_receiver_top");
      end
      $finish;
   end

endmodule

// ===== firmware_upload_frame_receiver_top.f =====
+incdir+rtl/core
rtl/core/fwup_pkg.sv
rtl/core/fwup_ctrl.sv
rtl/core/fwup_dp.sv
rtl/core/firmware_upload_frame_receiver_top.sv
tb/tb.sv
